@@ src/half_duplex_uart_bit_engine_assert.svh @@
// Assertion helpers for the UART bit engine.
`ifndef HALF_DUPLEX_UART_BIT_ENGINE_ASSERT_SVH
`define HALF_DUPLEX_UART_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HDUB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HDUB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hdub_pkg.sv @@
package hdub_pkg;

    // Default number of data bits per frame
    localparam int DATA_BITS_DEF = 8;

    // Register reset values
    localparam logic [7:0] BIT_TIME_RESET       = 8'd13;
    localparam logic [7:0] RX_FIRST_DELAY_RESET = 8'd13;

    // Configuration register indexes
    localparam logic CFG_BIT_TIME       = 1'b0;
    localparam logic CFG_RX_FIRST_DELAY = 1'b1;

    // Item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // One input item
    typedef struct packed {
        logic       command;
        logic       rxd_level;
        logic [7:0] tx_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic       txd_level;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       tx_busy;
        logic       rx_busy;
        logic       send_accepted;
    } result_t;

endpackage

@@ src/hdub_core.sv @@
module hdub_core
    import hdub_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  item_t      item,
    input  logic [7:0] bit_time,
    input  logic [7:0] rx_first_delay,
    output result_t    result
);

    localparam int SW   = DATA_BITS + 2;
    localparam int BLW  = $clog2(DATA_BITS + 3);
    localparam int IDXW = $clog2(DATA_BITS);

    logic [7:0]           tick_down_reg, tick_down_next;
    logic                 timer_on_reg, timer_on_next;
    logic [SW-1:0]        tx_shift_reg, tx_shift_next;
    logic [BLW-1:0]       tx_bits_left_reg, tx_bits_left_next;
    logic                 tx_active_reg, tx_active_next;
    logic                 line_out_reg, line_out_next;
    logic                 rx_active_reg, rx_active_next;
    logic [DATA_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic [IDXW-1:0]      rx_bit_index_reg, rx_bit_index_next;
    logic                 prev_rxd_reg, prev_rxd_next;

    logic                 rx_done;
    logic                 accepted;
    logic [DATA_BITS+7:0] tx_ext;
    logic [DATA_BITS+7:0] rx_ext;

    // Frame data and reported byte, resized to the frame width
    assign tx_ext = {{DATA_BITS{1'b0}}, item.tx_byte};
    assign rx_ext = {8'd0, rx_shift_next};

    // Next state for one item
    always_comb
    begin
        tick_down_next    = tick_down_reg;
        timer_on_next     = timer_on_reg;
        tx_shift_next     = tx_shift_reg;
        tx_bits_left_next = tx_bits_left_reg;
        tx_active_next    = tx_active_reg;
        line_out_next     = line_out_reg;
        rx_active_next    = rx_active_reg;
        rx_shift_next     = rx_shift_reg;
        rx_bit_index_next = rx_bit_index_reg;
        prev_rxd_next     = prev_rxd_reg;
        rx_done           = 1'b0;
        accepted          = 1'b0;

        if (item.command == CMD_SEND)
        begin
            // Load a frame only with both directions idle
            if (!tx_active_reg && !rx_active_reg)
            begin
                tx_shift_next     = {1'b1, tx_ext[DATA_BITS-1:0], 1'b0};
                tx_bits_left_next = BLW'(DATA_BITS + 2);
                tx_active_next    = 1'b1;
                line_out_next     = 1'b1;
                tick_down_next    = bit_time;
                timer_on_next     = 1'b1;
                accepted          = 1'b1;
            end
        end
        else
        begin
            priority if (!rx_active_reg && prev_rxd_reg && !item.rxd_level)
            begin
                // Start edge: reception wins, transmission is abandoned
                rx_active_next    = 1'b1;
                rx_shift_next     = '0;
                rx_bit_index_next = '0;
                tick_down_next    = rx_first_delay;
                timer_on_next     = 1'b1;
                tx_active_next    = 1'b0;
                tx_bits_left_next = '0;
                tx_shift_next     = '0;
                line_out_next     = 1'b1;
            end
            else if (timer_on_reg)
            begin
                if (tick_down_reg > 8'd1)
                begin
                    tick_down_next = tick_down_reg - 8'd1;
                end
                else
                begin
                    // Bit period elapsed
                    tick_down_next = bit_time;
                    if (rx_active_reg)
                    begin
                        rx_shift_next[rx_bit_index_reg] = item.rxd_level;
                        if (rx_bit_index_reg == IDXW'(DATA_BITS - 1))
                        begin
                            rx_active_next    = 1'b0;
                            timer_on_next     = 1'b0;
                            rx_bit_index_next = '0;
                            rx_done           = 1'b1;
                        end
                        else
                        begin
                            rx_bit_index_next = rx_bit_index_reg + IDXW'(1);
                        end
                    end
                    else if (tx_bits_left_reg == '0)
                    begin
                        timer_on_next  = 1'b0;
                        tx_active_next = 1'b0;
                    end
                    else
                    begin
                        line_out_next     = tx_shift_reg[0];
                        tx_shift_next     = {1'b0, tx_shift_reg[SW-1:1]};
                        tx_bits_left_next = tx_bits_left_reg - BLW'(1);
                    end
                end
            end
            prev_rxd_next = item.rxd_level;
        end
    end

    // Result as seen after the item
    always_comb
    begin
        result.txd_level     = line_out_next;
        result.rx_valid      = rx_done;
        result.rx_data       = rx_done ? rx_ext[7:0] : 8'd0;
        result.tx_busy       = tx_active_next;
        result.rx_busy       = rx_active_next;
        result.send_accepted = accepted;
    end

    // State registers, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_down_reg    <= '0;
            timer_on_reg     <= 1'b0;
            tx_shift_reg     <= '0;
            tx_bits_left_reg <= '0;
            tx_active_reg    <= 1'b0;
            line_out_reg     <= 1'b1;
            rx_active_reg    <= 1'b0;
            rx_shift_reg     <= '0;
            rx_bit_index_reg <= '0;
            prev_rxd_reg     <= 1'b1;
        end
        else if (step)
        begin
            tick_down_reg    <= tick_down_next;
            timer_on_reg     <= timer_on_next;
            tx_shift_reg     <= tx_shift_next;
            tx_bits_left_reg <= tx_bits_left_next;
            tx_active_reg    <= tx_active_next;
            line_out_reg     <= line_out_next;
            rx_active_reg    <= rx_active_next;
            rx_shift_reg     <= rx_shift_next;
            rx_bit_index_reg <= rx_bit_index_next;
            prev_rxd_reg     <= prev_rxd_next;
        end
    end

endmodule

@@ src/half_duplex_uart_bit_engine.sv @@
// Half-duplex 8N1 UART bit engine stepped by timer-tick items. Each input
// transfer is either a timer tick carrying a sample of the receive line, or a
// request to send a byte; each one yields exactly one result transfer with the
// transmit line level, busy flags, send acceptance and, when a byte finishes,
// the received byte. The block takes one item per clock unless the input
// register is stalled: an item sits in the input register, the frame state
// advances as it moves on, and its result is then captured in the result
// register. A stalled result holds in the result register while the input
// register still takes one more item. Registers bit_time and rx_first_delay
// (0 acts like 1) should be written only while the engine is idle.
`include "half_duplex_uart_bit_engine_assert.svh"

module half_duplex_uart_bit_engine
    import hdub_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // Item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic       rxd_level,
    input  logic [7:0] tx_byte,
    // Result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       txd_level,
    output logic       rx_valid,
    output logic [7:0] rx_data,
    output logic       tx_busy,
    output logic       rx_busy,
    output logic       send_accepted,
    // Configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] bit_time_reg;
    logic [7:0] rx_first_delay_reg;
    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       out_free;
    logic       step;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg       <= BIT_TIME_RESET;
            rx_first_delay_reg <= RX_FIRST_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIT_TIME:       bit_time_reg       <= cfg_data;
                CFG_RX_FIRST_DELAY: rx_first_delay_reg <= cfg_data;
                default:            bit_time_reg       <= bit_time_reg;
            endcase
        end
    end

    // Flow control: the result register frees when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.command   <= command;
            item_reg.rxd_level <= rxd_level;
            item_reg.tx_byte   <= tx_byte;
        end
    end

    // Frame state and per-item logic
    hdub_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .item           (item_reg),
        .bit_time       (bit_time_reg),
        .rx_first_delay (rx_first_delay_reg),
        .result         (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign txd_level     = result_reg.txd_level;
    assign rx_valid      = result_reg.rx_valid;
    assign rx_data       = result_reg.rx_data;
    assign tx_busy       = result_reg.tx_busy;
    assign rx_busy       = result_reg.rx_busy;
    assign send_accepted = result_reg.send_accepted;

    // A finished byte ends the reception it belongs to
    `HDUB_ASSERT_NOW(a_rx_done_idle, clk, rst_n, out_valid_reg && result_reg.rx_valid, !result_reg.rx_busy, "byte delivered while reception still busy")
    // An accepted send leaves a transmission running and no reception
    `HDUB_ASSERT_NOW(a_send_state, clk, rst_n, out_valid_reg && result_reg.send_accepted, result_reg.tx_busy && !result_reg.rx_busy, "accepted send without transmit-only state")
    // A stalled result stays in place while the input stage fills
    `HDUB_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid_reg && out_stall, out_valid_reg && $stable(result_reg), "stalled result changed")

endmodule

@@ dv/half_duplex_uart_bit_engine_tb.sv @@
`timescale 1ns / 1ps

module half_duplex_uart_bit_engine_tb;
    import hdub_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       command;
    logic       rxd_level;
    logic [7:0] tx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       txd_level;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       tx_busy;
    logic       rx_busy;
    logic       send_accepted;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [7:0] cfg_data;

    half_duplex_uart_bit_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .rxd_level     (rxd_level),
        .tx_byte       (tx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .txd_level     (txd_level),
        .rx_valid      (rx_valid),
        .rx_data       (rx_data),
        .tx_busy       (tx_busy),
        .rx_busy       (rx_busy),
        .send_accepted (send_accepted),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Results that can be read straight off the frame rules
    localparam result_t R_IDLE      = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
    localparam result_t R_TX_START  = '{1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1};
    localparam result_t R_TX_DROP   = '{1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0};
    localparam result_t R_RX_BUSY   = '{1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0};
    localparam result_t R_START_BIT = '{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0};

    localparam int N_PHASES = 8;

    // Directed rows; rows with typed == 0 are checked against the engine model
    typedef struct {
        logic       cmd;
        logic       rxd;
        logic [7:0] data;
        int         reps;
        bit         typed;
        result_t    want;
    } plan_row_t;

    plan_row_t plan [25] = '{
        '{CMD_TICK, 1'b1, 8'h00,   1, 1'b1, R_IDLE},
        '{CMD_SEND, 1'b1, 8'hFF,   1, 1'b1, R_TX_START},
        '{CMD_SEND, 1'b1, 8'h00,   1, 1'b1, R_TX_DROP},
        '{CMD_TICK, 1'b1, 8'h00, 150, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b1, 8'h00,   1, 1'b1, R_IDLE},
        '{CMD_SEND, 1'b0, 8'h00,   1, 1'b1, R_TX_START},
        '{CMD_TICK, 1'b1, 8'h00,  30, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b0, 8'h00,   1, 1'b1, R_RX_BUSY},
        '{CMD_SEND, 1'b0, 8'hA5,   1, 1'b1, R_RX_BUSY},
        '{CMD_TICK, 1'b0, 8'h00,  12, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b1, 8'h00, 110, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b1, 8'h00,   1, 1'b1, R_IDLE},
        '{CMD_TICK, 1'b0, 8'h00,   1, 1'b1, R_RX_BUSY},
        '{CMD_TICK, 1'b0, 8'h00, 110, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b1, 8'h00,   1, 1'b1, R_IDLE},
        '{CMD_SEND, 1'b1, 8'h80,   1, 1'b1, R_TX_START},
        '{CMD_TICK, 1'b1, 8'h00,  12, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b1, 8'h00,   1, 1'b1, R_START_BIT},
        '{CMD_TICK, 1'b1, 8'h00, 150, 1'b0, R_IDLE},
        '{CMD_SEND, 1'b1, 8'h01,   1, 1'b1, R_TX_START},
        '{CMD_TICK, 1'b1, 8'h00,  40, 1'b0, R_IDLE},
        '{CMD_TICK, 1'b0, 8'h00,   1, 1'b1, R_RX_BUSY},
        '{CMD_TICK, 1'b1, 8'h00, 120, 1'b0, R_IDLE},
        '{CMD_SEND, 1'b1, 8'h3C,   1, 1'b1, R_TX_START},
        '{CMD_TICK, 1'b1, 8'h00, 150, 1'b0, R_IDLE}
    };

    // Register settings per phase; -1 picks a random value
    int phase_bit   [N_PHASES] = '{1, 0, 2, 5,  1,   3, -1, -1};
    int phase_first [N_PHASES] = '{1, 0, 7, 20, 255, 1, -1, -1};
    int phase_items [N_PHASES] = '{100, 40, 50, 60, 30, 40, 50, 50};

    // Engine model: register copies and frame state
    logic [7:0] bit_period;
    logic [7:0] first_delay;
    logic [7:0] ticks_left;
    logic       timer_run;
    logic [9:0] frame_shift;
    logic [3:0] frame_bits_left;
    logic       tx_on;
    logic       line_level;
    logic       rx_on;
    logic [7:0] rx_byte_acc;
    logic [2:0] rx_pos;
    logic       last_rxd;

    result_t pending_results [$];
    logic    line_plan [$];
    int      fail_count;
    int      burst_left;
    bit      hold_request;
    result_t head_result;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("half_duplex_uart_bit_engine regression: fail");
        $finish;
    end

    // Advance the engine model by one item and return its result
    function automatic result_t step_engine(input item_t it);
        result_t res;
        logic    done;
        res  = '0;
        done = 1'b0;
        if (it.command == CMD_SEND)
        begin
            if (!tx_on && !rx_on)
            begin
                frame_shift     = {1'b1, it.tx_byte, 1'b0};
                frame_bits_left = 4'(DATA_BITS_DEF + 2);
                tx_on           = 1'b1;
                line_level      = 1'b1;
                ticks_left      = bit_period;
                timer_run       = 1'b1;
                res.send_accepted = 1'b1;
            end
        end
        else
        begin
            // falling edge on an idle receiver wins over the timer
            if (!rx_on && last_rxd && !it.rxd_level)
            begin
                rx_on           = 1'b1;
                rx_byte_acc     = '0;
                rx_pos          = '0;
                ticks_left      = first_delay;
                timer_run       = 1'b1;
                tx_on           = 1'b0;
                frame_bits_left = '0;
                frame_shift     = '0;
                line_level      = 1'b1;
            end
            else if (timer_run)
            begin
                if (ticks_left > 8'd1)
                    ticks_left = ticks_left - 8'd1;
                else
                begin
                    ticks_left = bit_period;
                    if (rx_on)
                    begin
                        rx_byte_acc[rx_pos] = it.rxd_level;
                        if (rx_pos == 3'(DATA_BITS_DEF - 1))
                        begin
                            rx_on     = 1'b0;
                            timer_run = 1'b0;
                            rx_pos    = '0;
                            done      = 1'b1;
                        end
                        else
                            rx_pos = rx_pos + 3'd1;
                    end
                    else if (frame_bits_left == 4'd0)
                    begin
                        timer_run = 1'b0;
                        tx_on     = 1'b0;
                    end
                    else
                    begin
                        line_level      = frame_shift[0];
                        frame_shift     = frame_shift >> 1;
                        frame_bits_left = frame_bits_left - 4'd1;
                    end
                end
            end
            last_rxd = it.rxd_level;
        end
        res.txd_level = line_level;
        res.rx_valid  = done;
        res.rx_data   = done ? rx_byte_acc : 8'h00;
        res.tx_busy   = tx_on;
        res.rx_busy   = rx_on;
        return res;
    endfunction

    // Idle cycles after a transfer: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 120);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item, wait for the transfer, queue its expected result
    task automatic push_item(input logic cmd, input logic rxd, input logic [7:0] data,
                             input bit typed, input result_t want);
        item_t   it;
        result_t pred;
        int      gap;
        it.command   = cmd;
        it.rxd_level = rxd;
        it.tx_byte   = data;
        @(negedge clk);
        in_valid  <= 1'b1;
        command   <= cmd;
        rxd_level <= rxd;
        tx_byte   <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = step_engine(it);
        pending_results.push_back(typed ? want : pred);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // Stop offering and wait for every expected result, plus pipeline latency
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_BIT_TIME)
            bit_period = value;
        else
            first_delay = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random item: mostly well-formed frames on the line, some noise
    task automatic random_item();
        int         r;
        int         bt;
        int         fd;
        int         t;
        int         idx;
        logic [7:0] data;
        bt = (bit_period == 8'd0) ? 1 : int'(bit_period);
        fd = (first_delay == 8'd0) ? 1 : int'(first_delay);
        // stray sends, accepted or dropped depending on state
        if ($urandom_range(0, 99) < 4)
        begin
            push_item(CMD_SEND, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'b0, '0);
            return;
        end
        if (line_plan.size() == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                // receive frame: mark, start bit, data held one bit period each, stop
                data = 8'($urandom_range(0, 255));
                line_plan.push_back(1'b1);
                for (t = 0; t < fd + 9 * bt; t++)
                begin
                    if (t < fd)
                        line_plan.push_back(1'b0);
                    else
                    begin
                        idx = (t - fd) / bt;
                        line_plan.push_back(idx < 8 ? data[idx] : 1'b1);
                    end
                end
                repeat ($urandom_range(0, 3))
                    line_plan.push_back(1'b1);
            end
            else if (r < 70)
            begin
                // send a byte and leave the line at mark long enough to finish it
                push_item(CMD_SEND, 1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
                repeat (11 * bt + 2)
                    line_plan.push_back(1'b1);
                return;
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 20))
                    line_plan.push_back(1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    line_plan.push_back(1'($urandom_range(0, 1)));
            end
        end
        push_item(CMD_TICK, line_plan.pop_front(), 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic field_check(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    // Result side: compare every transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end
            else
            begin
                head_result = pending_results.pop_front();
                field_check("txd_level", head_result.txd_level, txd_level);
                field_check("rx_valid", head_result.rx_valid, rx_valid);
                field_check("rx_data", head_result.rx_data, rx_data);
                field_check("tx_busy", head_result.tx_busy, tx_busy);
                field_check("rx_busy", head_result.rx_busy, rx_busy);
                field_check("send_accepted", head_result.send_accepted, send_accepted);
            end
        end
    end

    // Result stall: short bursts, long holds now and then, one forced long hold
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        out_stall  = 1'b0;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = 300;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    free_left = $urandom_range(1, 60);
                else if (r < 93)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(10, 60);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    // Stimulus
    initial
    begin
        int k;
        int j;
        int p;
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_TICK;
        rxd_level    = 1'b1;
        tx_byte      = 8'h00;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_BIT_TIME;
        cfg_data     = 8'h00;
        fail_count   = 0;
        burst_left   = 0;
        hold_request = 1'b0;

        bit_period      = BIT_TIME_RESET;
        first_delay     = RX_FIRST_DELAY_RESET;
        ticks_left      = '0;
        timer_run       = 1'b0;
        frame_shift     = '0;
        frame_bits_left = '0;
        tx_on           = 1'b0;
        line_level      = 1'b1;
        rx_on           = 1'b0;
        rx_byte_acc     = '0;
        rx_pos          = '0;
        last_rxd        = 1'b1;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed walk at reset register values
        for (k = 0; k < $size(plan); k++)
            for (j = 0; j < plan[k].reps; j++)
                push_item(plan[k].cmd, plan[k].rxd, plan[k].data, plan[k].typed,
                          plan[k].want);

        // random phases, each under its own register setting
        for (p = 0; p < N_PHASES; p++)
        begin
            // let any frame finish so the engine is quiet for the writes
            while (tx_on || rx_on)
                push_item(CMD_TICK, 1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            wait_drained();
            write_reg(CFG_BIT_TIME,
                      phase_bit[p] < 0 ? 8'($urandom_range(1, 6)) : 8'(phase_bit[p]));
            write_reg(CFG_RX_FIRST_DELAY,
                      phase_first[p] < 0 ? 8'($urandom_range(0, 12)) : 8'(phase_first[p]));
            line_plan.delete();
            for (i = 0; i < phase_items[p]; i++)
            begin
                // first phase: long result hold, later a full sender pause
                if (p == 0 && i == 20)
                    hold_request = 1'b1;
                if (p == 0 && i == 70)
                    wait_drained();
                random_item();
            end
        end

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("half_duplex_uart_bit_engine regression: pass");
        else
            $display("half_duplex_uart_bit_engine regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/hdub_pkg.sv
src/hdub_core.sv
src/half_duplex_uart_bit_engine.sv
dv/half_duplex_uart_bit_engine_tb.sv
